>>> design/dda_pkg.sv
// Shared types, widths and codes for the clipped DDA line rasterizer.
// No dependencies; every other file of the block refers to it by scoped names.
`default_nettype none

package dda_pkg;

    // Fixed-point formats of endpoints and accumulators.
    localparam int COORD_FRAC_BITS = 4;
    localparam int STEP_FRAC_BITS  = 16;

    // Field widths of the input and result words.
    localparam int COORD_W   = 16;
    localparam int WIN_W     = 12;
    localparam int PIX_OUT_W = 12;
    localparam int COLOR_W   = 24;
    localparam int FRAME_W   = 11;

    // Derived datapath widths.
    localparam int DIFF_W    = COORD_W + 1;
    localparam int DELTA_W   = COORD_W;
    localparam int SUM_W     = DELTA_W + 1;
    localparam int STEPS_W   = SUM_W - COORD_FRAC_BITS;
    localparam int QUO_W     = STEP_FRAC_BITS + 1;
    localparam int INC_W     = QUO_W + 1;
    localparam int ACC_SHIFT = STEP_FRAC_BITS - COORD_FRAC_BITS;
    localparam int ACC_W     = COORD_W + ACC_SHIFT + 1;
    localparam int PIX_W     = ACC_W - STEP_FRAC_BITS;
    localparam int CMP_W     = ((PIX_W > WIN_W + 1) ? PIX_W : WIN_W + 1) + 1;
    localparam int CNT_W     = $clog2(QUO_W);
    localparam int ROUND_UP  = (1 << COORD_FRAC_BITS) - 1;

    localparam logic [SUM_W-1:0] STEP_ROUND    = SUM_W'(ROUND_UP);
    localparam logic [ACC_W-1:0] ACC_FRAC_MASK = ACC_W'((1 << STEP_FRAC_BITS) - 1);
    localparam logic [CNT_W-1:0] DIV_LAST      = CNT_W'(QUO_W - 1);

    // Configuration port.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = FRAME_W;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = CFG_IDX_W'(1);

    localparam logic [FRAME_W-1:0] FRAME_WIDTH_RST  = FRAME_W'(400);
    localparam logic [FRAME_W-1:0] FRAME_HEIGHT_RST = FRAME_W'(294);

    // Kind of an input word.
    typedef enum logic {
        KIND_LINE = 1'b0,
        KIND_STEP = 1'b1
    } t_kind;

    typedef struct packed {
        t_kind                      kind;
        logic signed [COORD_W-1:0]  start_x;
        logic signed [COORD_W-1:0]  start_y;
        logic signed [COORD_W-1:0]  end_x;
        logic signed [COORD_W-1:0]  end_y;
        logic        [COLOR_W-1:0]  line_color;
        logic signed [WIN_W-1:0]    window_x;
        logic signed [WIN_W-1:0]    window_y;
    } t_line_word;

    typedef struct packed {
        logic signed [PIX_OUT_W-1:0] pixel_x;
        logic signed [PIX_OUT_W-1:0] pixel_y;
        logic        [COLOR_W-1:0]   pixel_color;
        logic                        write_enable;
        logic                        last;
    } t_pix_word;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_line;
        logic setup;
        logic find_max;
        logic div_init;
        logic div_step;
        logic div_first;
        logic load_inc;
        logic emit_pixel;
        logic emit_empty;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic line_active;
        logic len_zero;
    } t_dp_stat;

endpackage

`default_nettype wire

>>> design/dda_line_if.sv
// Input channel of the rasterizer: valid/ready handshake carrying a line word.
// Depends on dda_pkg for the word type.
`default_nettype none

interface dda_line_if;
    logic                valid;
    logic                ready;
    dda_pkg::t_line_word word;

    modport source (output valid, output word, input ready);
    modport sink   (input valid, input word, output ready);
endinterface

`default_nettype wire

>>> design/dda_pix_if.sv
// Output channel of the rasterizer: valid/ready handshake carrying a pixel word.
// Depends on dda_pkg for the word type.
`default_nettype none

interface dda_pix_if;
    logic               valid;
    logic               ready;
    dda_pkg::t_pix_word word;

    modport source (output valid, output word, input ready);
    modport sink   (input valid, input word, output ready);
endinterface

`default_nettype wire

>>> design/clipped_dda_line_rasterizer.sv
// Top level of the clipped DDA line rasterizer: joins controller and datapath.
// Depends on dda_pkg, dda_line_if, dda_pix_if, dda_ctrl and dda_dp.
//
//   Channel   Dir  Handshake        Word
//   i_line    in   valid / ready    kind, endpoints, color, window origin
//   o_pix     out  valid / ready    pixel x/y, color, write flag, last
//   i_cfg_*   in   write enable     frame_width (index 0), frame_height (index 1)
//
// A step word gives one pixel from the accumulators, or an empty word
// when no line is active. A line word runs setup, step count, then the
// 17-step serial divide for the increments, before pixel 0 is registered.
// A zero-length line gives a single empty word in place of pixels.
// Reset is synchronous and active low; it resets control state only.
// A word waits in the output register while o_pix is stalled; input is
// taken again in the cycle the pending word is taken.
`default_nettype none

module clipped_dda_line_rasterizer (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [dda_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [dda_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    dda_line_if.sink                            i_line,
    dda_pix_if.source                           o_pix
);

    dda_pkg::t_dp_cmd  cmd;
    dda_pkg::t_dp_stat stat;

    dda_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_line.valid),
        .i_in_kind   (i_line.word.kind),
        .o_in_ready  (i_line.ready),
        .i_out_ready (o_pix.ready),
        .o_out_valid (o_pix.valid),
        .o_cmd       (cmd),
        .i_stat      (stat)
    );

    dda_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_word      (i_line.word),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_word      (o_pix.word)
    );

`ifndef NO_ASSERTIONS
    // A line word blocks input while its setup runs.
    a_line_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_line.valid && i_line.ready && i_line.word.kind == dda_pkg::KIND_LINE)
        |=> !i_line.ready)
        else $error("input ready during line setup");

    // A step word always yields a word in the next cycle.
    a_step_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_line.valid && i_line.ready && i_line.word.kind == dda_pkg::KIND_STEP)
        |=> o_pix.valid)
        else $error("step word produced no output word");

    // A pending word that is not last implies the line is still running.
    a_not_last_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pix.valid && !o_pix.word.last) |-> stat.line_active)
        else $error("non-last pixel without an active line");
`endif

endmodule

`default_nettype wire

>>> design/dda_div.sv
// Bit-serial restoring divider that forms one increment magnitude, one
// quotient bit per step. Depends on dda_pkg for widths.
`default_nettype none

module dda_div (
    input  wire logic                        i_clk,
    input  wire logic                        i_init,
    input  wire logic                        i_step,
    input  wire logic                        i_first,
    input  wire logic [dda_pkg::DELTA_W-1:0] i_num,
    input  wire logic [dda_pkg::DELTA_W-1:0] i_den,
    output logic      [dda_pkg::QUO_W-1:0]   o_quo
);

    logic [dda_pkg::DELTA_W-1:0] r_rem;
    logic [dda_pkg::QUO_W-1:0]   r_quo;
    logic [dda_pkg::DELTA_W-1:0] n_rem;
    logic [dda_pkg::DELTA_W:0]   trial;
    logic [dda_pkg::DELTA_W:0]   diff;
    logic                        ge;

    // The first step tests the integer bit without a shift; the numerator never
    // exceeds the divisor, so the remainder always stays below the divisor.
    always_comb begin
        trial = i_first ? {1'b0, r_rem} : {r_rem, 1'b0};
        diff  = trial - {1'b0, i_den};
        ge    = (trial >= {1'b0, i_den});
        n_rem = ge ? diff[dda_pkg::DELTA_W-1:0] : trial[dda_pkg::DELTA_W-1:0];
    end

    // Remainder and quotient shift register.
    always_ff @(posedge i_clk) begin
        if (i_init) begin
            r_rem <= i_num;
            r_quo <= '0;
        end else if (i_step) begin
            r_rem <= n_rem;
            r_quo <= {r_quo[dda_pkg::QUO_W-2:0], ge};
        end
    end

    assign o_quo = r_quo;

endmodule

`default_nettype wire

>>> design/dda_ctrl.sv
// Controller of the rasterizer: sequences line setup, the serial division and
// pixel emission, and owns both handshakes. Depends on dda_pkg.
`default_nettype none

module dda_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  dda_pkg::t_kind         i_in_kind,
    output logic                   o_in_ready,
    input  wire logic              i_out_ready,
    output logic                   o_out_valid,
    output dda_pkg::t_dp_cmd       o_cmd,
    input  dda_pkg::t_dp_stat      i_stat
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SETUP,
        S_MAX,
        S_DIV,
        S_INC,
        S_FIRST
    } t_state;

    t_state                    r_state;
    t_state                    n_state;
    logic [dda_pkg::CNT_W-1:0] r_cnt;
    logic [dda_pkg::CNT_W-1:0] n_cnt;
    logic                      r_out_valid;
    logic                      n_out_valid;
    logic                      out_free;
    dda_pkg::t_dp_cmd          cmd;

    // Next state, commands and input ready.
    always_comb begin
        out_free   = !r_out_valid || i_out_ready;
        cmd        = '0;
        n_state    = r_state;
        n_cnt      = r_cnt;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = out_free;
                if (i_in_valid && out_free) begin
                    if (i_in_kind == dda_pkg::KIND_LINE) begin
                        cmd.load_line = 1'b1;
                        n_state       = S_SETUP;
                    end else if (i_stat.line_active) begin
                        cmd.emit_pixel = 1'b1;
                    end else begin
                        cmd.emit_empty = 1'b1;
                    end
                end
            end
            S_SETUP: begin
                cmd.setup = 1'b1;
                n_state   = S_MAX;
            end
            S_MAX: begin
                cmd.find_max = 1'b1;
                cmd.div_init = 1'b1;
                n_cnt        = '0;
                n_state      = S_DIV;
            end
            S_DIV: begin
                if (i_stat.len_zero) begin
                    // A zero-length line ends with an empty word.
                    if (out_free) begin
                        cmd.emit_empty = 1'b1;
                        n_state        = S_IDLE;
                    end
                end else begin
                    cmd.div_step  = 1'b1;
                    cmd.div_first = (r_cnt == '0);
                    n_cnt         = r_cnt + dda_pkg::CNT_W'(1);
                    if (r_cnt == dda_pkg::DIV_LAST) begin
                        n_state = S_INC;
                    end
                end
            end
            S_INC: begin
                cmd.load_inc = 1'b1;
                n_state      = S_FIRST;
            end
            S_FIRST: begin
                if (out_free) begin
                    cmd.emit_pixel = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_out_valid = (cmd.emit_pixel || cmd.emit_empty) ? 1'b1 :
                      (i_out_ready ? 1'b0 : r_out_valid);
    end

    // State, division counter and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_cmd       = cmd;
    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

>>> design/dda_dp.sv
// Datapath of the rasterizer: endpoint registers, step count, two serial
// dividers, accumulators, window test and the output word register.
// Depends on dda_pkg and dda_div.
`default_nettype none

module dda_dp (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  dda_pkg::t_dp_cmd                    i_cmd,
    output dda_pkg::t_dp_stat                   o_stat,
    input  dda_pkg::t_line_word                 i_word,
    input  wire logic                           i_cfg_we,
    input  wire logic [dda_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [dda_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    output dda_pkg::t_pix_word                  o_word
);

    // Truncate an accumulator toward zero to a whole pixel.
    function automatic logic signed [dda_pkg::PIX_W-1:0] to_pixel(
        input logic signed [dda_pkg::ACC_W-1:0] acc
    );
        logic [dda_pkg::ACC_W-1:0] biased;
        biased = acc + (acc[dda_pkg::ACC_W-1] ? dda_pkg::ACC_FRAC_MASK : '0);
        return biased[dda_pkg::ACC_W-1:dda_pkg::STEP_FRAC_BITS];
    endfunction

    // Control registers.
    logic [dda_pkg::FRAME_W-1:0] r_frame_w;
    logic [dda_pkg::FRAME_W-1:0] r_frame_h;
    logic [dda_pkg::STEPS_W-1:0] r_left;

    // Line registers.
    logic signed [dda_pkg::COORD_W-1:0] r_sx, r_sy, r_ex, r_ey;
    logic        [dda_pkg::COLOR_W-1:0] r_color;
    logic signed [dda_pkg::WIN_W-1:0]   r_win_x, r_win_y;
    logic        [dda_pkg::DELTA_W-1:0] r_dx_mag, r_dy_mag, r_m;
    logic                               r_dy_neg;
    logic signed [dda_pkg::ACC_W-1:0]   r_acc_x, r_acc_y;
    logic signed [dda_pkg::INC_W-1:0]   r_inc_x, r_inc_y;
    dda_pkg::t_pix_word                 r_out;

    // Combinational values.
    logic                               swap;
    logic signed [dda_pkg::DIFF_W-1:0]  dx_full, dy_up, dy_down;
    logic                               dy_neg;
    logic signed [dda_pkg::ACC_W-1:0]   acc_sx, acc_sy;
    logic        [dda_pkg::DELTA_W-1:0] m;
    logic        [dda_pkg::SUM_W-1:0]   steps_sum;
    logic        [dda_pkg::QUO_W-1:0]   quo_x, quo_y;
    logic signed [dda_pkg::INC_W-1:0]   inc_x_mag, inc_y_mag;
    logic signed [dda_pkg::PIX_W-1:0]   px, py;
    logic signed [dda_pkg::CMP_W-1:0]   px_c, py_c, wx_c, wy_c, fw_c, fh_c, wx_hi, wy_hi;
    logic                               in_window;
    dda_pkg::t_pix_word                 pix_word;
    dda_pkg::t_pix_word                 empty_word;

    // Endpoint order, deltas, step count and increments.
    always_comb begin
        swap      = (i_word.start_x > i_word.end_x);
        dx_full   = dda_pkg::DIFF_W'(r_ex) - dda_pkg::DIFF_W'(r_sx);
        dy_up     = dda_pkg::DIFF_W'(r_ey) - dda_pkg::DIFF_W'(r_sy);
        dy_down   = dda_pkg::DIFF_W'(r_sy) - dda_pkg::DIFF_W'(r_ey);
        dy_neg    = (r_sy > r_ey);
        acc_sx    = dda_pkg::ACC_W'(r_sx) <<< dda_pkg::ACC_SHIFT;
        acc_sy    = dda_pkg::ACC_W'(r_sy) <<< dda_pkg::ACC_SHIFT;
        m         = (r_dx_mag > r_dy_mag) ? r_dx_mag : r_dy_mag;
        steps_sum = dda_pkg::SUM_W'(m) + dda_pkg::STEP_ROUND;
        inc_x_mag = $signed({1'b0, quo_x});
        inc_y_mag = $signed({1'b0, quo_y});
    end

    // Pixel position and strict window test from the current accumulators.
    always_comb begin
        px     = to_pixel(r_acc_x);
        py     = to_pixel(r_acc_y);
        px_c   = dda_pkg::CMP_W'(px);
        py_c   = dda_pkg::CMP_W'(py);
        wx_c   = dda_pkg::CMP_W'(r_win_x);
        wy_c   = dda_pkg::CMP_W'(r_win_y);
        fw_c   = dda_pkg::CMP_W'(r_frame_w);
        fh_c   = dda_pkg::CMP_W'(r_frame_h);
        wx_hi  = wx_c + fw_c;
        wy_hi  = wy_c + fh_c;
        in_window = (px_c > wx_c) && (px_c < wx_hi) && (py_c > wy_c) && (py_c < wy_hi);

        pix_word.pixel_x      = px[dda_pkg::PIX_OUT_W-1:0];
        pix_word.pixel_y      = py[dda_pkg::PIX_OUT_W-1:0];
        pix_word.pixel_color  = r_color;
        pix_word.write_enable = in_window;
        pix_word.last         = (r_left == dda_pkg::STEPS_W'(1));

        empty_word      = '0;
        empty_word.last = 1'b1;
    end

    // Increment dividers, one per axis, sharing the step sequence.
    dda_div u_div_x (
        .i_clk   (i_clk),
        .i_init  (i_cmd.div_init),
        .i_step  (i_cmd.div_step),
        .i_first (i_cmd.div_first),
        .i_num   (r_dx_mag),
        .i_den   (r_m),
        .o_quo   (quo_x)
    );

    dda_div u_div_y (
        .i_clk   (i_clk),
        .i_init  (i_cmd.div_init),
        .i_step  (i_cmd.div_step),
        .i_first (i_cmd.div_first),
        .i_num   (r_dy_mag),
        .i_den   (r_m),
        .o_quo   (quo_y)
    );

    // Window size registers and the count of pixels still to emit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_w <= dda_pkg::FRAME_WIDTH_RST;
            r_frame_h <= dda_pkg::FRAME_HEIGHT_RST;
            r_left    <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    dda_pkg::REG_FRAME_WIDTH:  r_frame_w <= i_cfg_wdata;
                    dda_pkg::REG_FRAME_HEIGHT: r_frame_h <= i_cfg_wdata;
                    default: begin
                    end
                endcase
            end
            if (i_cmd.load_line) begin
                r_left <= '0;
            end else if (i_cmd.find_max) begin
                r_left <= steps_sum[dda_pkg::SUM_W-1:dda_pkg::COORD_FRAC_BITS];
            end else if (i_cmd.emit_pixel) begin
                r_left <= r_left - dda_pkg::STEPS_W'(1);
            end
        end
    end

    // Line data, accumulators and the output word.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_line) begin
            r_sx    <= swap ? i_word.end_x   : i_word.start_x;
            r_sy    <= swap ? i_word.end_y   : i_word.start_y;
            r_ex    <= swap ? i_word.start_x : i_word.end_x;
            r_ey    <= swap ? i_word.start_y : i_word.end_y;
            r_color <= i_word.line_color;
            r_win_x <= i_word.window_x;
            r_win_y <= i_word.window_y;
        end
        if (i_cmd.setup) begin
            r_dx_mag <= dx_full[dda_pkg::DELTA_W-1:0];
            r_dy_mag <= dy_neg ? dy_down[dda_pkg::DELTA_W-1:0] : dy_up[dda_pkg::DELTA_W-1:0];
            r_dy_neg <= dy_neg;
            r_acc_x  <= acc_sx;
            r_acc_y  <= acc_sy;
        end
        if (i_cmd.find_max) begin
            r_m <= m;
        end
        if (i_cmd.load_inc) begin
            r_inc_x <= inc_x_mag;
            r_inc_y <= r_dy_neg ? -inc_y_mag : inc_y_mag;
        end
        // The accumulators run one pixel ahead of the word just emitted.
        if (i_cmd.emit_pixel) begin
            r_out   <= pix_word;
            r_acc_x <= r_acc_x + dda_pkg::ACC_W'(r_inc_x);
            r_acc_y <= r_acc_y + dda_pkg::ACC_W'(r_inc_y);
        end else if (i_cmd.emit_empty) begin
            r_out <= empty_word;
        end
    end

    assign o_stat.line_active = (r_left != '0);
    assign o_stat.len_zero    = (r_m == '0);
    assign o_word             = r_out;

endmodule

`default_nettype wire

>>> dv/clipped_dda_line_rasterizer_test.sv
// Self-checking testbench for clipped_dda_line_rasterizer: line and step words
// in, predicted pixel words compared as they come out. Depends on dda_pkg,
// dda_line_if, dda_pix_if and the rasterizer RTL.
`default_nettype none

module clipped_dda_line_rasterizer_test;

    localparam int QUIET_LIMIT   = 3000;  // cycles with no word moving before giving up
    localparam int SETTLE_CYCLES = 30;
    localparam int HOLD_AT       = 250;   // pixel count at which the sink holds off
    localparam int HOLD_CYCLES   = 200;
    localparam int REPORT_MAX    = 10;

    // Predicts every pixel word from the accepted input words and checks the
    // words that come out against the oldest prediction.
    class raster_scoreboard;
        dda_pkg::t_pix_word          expected_pixels[$];
        logic [dda_pkg::FRAME_W-1:0] frame_width;
        logic [dda_pkg::FRAME_W-1:0] frame_height;
        bit               drawing;
        longint           acc_x, acc_y, inc_x, inc_y;
        int               pixels_left;
        logic [dda_pkg::COLOR_W-1:0] pen_color;
        longint           clip_x, clip_y;
        int unsigned      mismatches, checked, lines_started, written, empties;

        function new();
            frame_width  = dda_pkg::FRAME_WIDTH_RST;
            frame_height = dda_pkg::FRAME_HEIGHT_RST;
            drawing      = 1'b0;
            acc_x        = 0;
            acc_y        = 0;
            inc_x        = 0;
            inc_y        = 0;
            pixels_left  = 0;
            pen_color    = '0;
            clip_x       = 0;
            clip_y       = 0;
        endfunction

        function void set_register(logic [dda_pkg::CFG_IDX_W-1:0] idx,
                                   logic [dda_pkg::FRAME_W-1:0] val);
            if (idx == dda_pkg::REG_FRAME_WIDTH) begin
                frame_width = val;
            end else if (idx == dda_pkg::REG_FRAME_HEIGHT) begin
                frame_height = val;
            end
        endfunction

        // Signed Q.16 increment, truncated toward zero.
        function longint step_increment(longint d, longint span);
            longint q;
            q = ((d < 0 ? -d : d) <<< dda_pkg::STEP_FRAC_BITS) / span;
            return (d < 0) ? -q : q;
        endfunction

        // Pixel at the accumulators; the window test uses the full-width pixel.
        function dda_pkg::t_pix_word pixel_at(bit is_last);
            longint             px, py;
            dda_pkg::t_pix_word p;
            px = acc_x / (longint'(1) <<< dda_pkg::STEP_FRAC_BITS);
            py = acc_y / (longint'(1) <<< dda_pkg::STEP_FRAC_BITS);
            p.pixel_x      = px[dda_pkg::PIX_OUT_W-1:0];
            p.pixel_y      = py[dda_pkg::PIX_OUT_W-1:0];
            p.pixel_color  = pen_color;
            p.write_enable = px > clip_x && px < clip_x + longint'(frame_width) &&
                             py > clip_y && py < clip_y + longint'(frame_height);
            p.last         = is_last;
            return p;
        endfunction

        function void note_word(dda_pkg::t_line_word w);
            longint             sx, sy, ex, ey, dx, dy, ax, ay, span, t;
            dda_pkg::t_pix_word p;
            p      = '0;
            p.last = 1'b1;
            if (w.kind == dda_pkg::KIND_LINE) begin
                sx = longint'(w.start_x);
                sy = longint'(w.start_y);
                ex = longint'(w.end_x);
                ey = longint'(w.end_y);
                // Draw left to right.
                if (sx > ex) begin
                    t = sx; sx = ex; ex = t;
                    t = sy; sy = ey; ey = t;
                end
                dx        = ex - sx;
                dy        = ey - sy;
                ax        = dx < 0 ? -dx : dx;
                ay        = dy < 0 ? -dy : dy;
                span      = ax > ay ? ax : ay;
                pen_color = w.line_color;
                clip_x    = longint'(w.window_x);
                clip_y    = longint'(w.window_y);
                if (span == 0) begin
                    drawing     = 1'b0;
                    pixels_left = 0;
                end else begin
                    inc_x       = step_increment(dx, span);
                    inc_y       = step_increment(dy, span);
                    acc_x       = sx * (longint'(1) <<<
                                        (dda_pkg::STEP_FRAC_BITS - dda_pkg::COORD_FRAC_BITS));
                    acc_y       = sy * (longint'(1) <<<
                                        (dda_pkg::STEP_FRAC_BITS - dda_pkg::COORD_FRAC_BITS));
                    pixels_left = int'((span + dda_pkg::ROUND_UP) >>>
                                       dda_pkg::COORD_FRAC_BITS) - 1;
                    drawing     = pixels_left != 0;
                    p           = pixel_at(!drawing);
                    lines_started++;
                end
            end else if (drawing) begin
                acc_x += inc_x;
                acc_y += inc_y;
                pixels_left--;
                drawing = pixels_left != 0;
                p       = pixel_at(!drawing);
            end
            expected_pixels.push_back(p);
        endfunction

        function void check_pixel(dda_pkg::t_pix_word got);
            dda_pkg::t_pix_word want;
            if (expected_pixels.size() == 0) begin
                if (mismatches < REPORT_MAX) begin
                    $display("unexpected pixel word x=%0d y=%0d color=%h we=%b last=%b",
                             got.pixel_x, got.pixel_y, got.pixel_color,
                             got.write_enable, got.last);
                end
                mismatches++;
                return;
            end
            want = expected_pixels.pop_front();
            checked++;
            if (want.write_enable) written++;
            if (want.last && !want.write_enable && want.pixel_color == '0 &&
                want.pixel_x == '0 && want.pixel_y == '0) empties++;
            if (got.pixel_x !== want.pixel_x || got.pixel_y !== want.pixel_y ||
                got.pixel_color !== want.pixel_color ||
                got.write_enable !== want.write_enable || got.last !== want.last) begin
                if (mismatches < REPORT_MAX) begin
                    $display("pixel %0d mismatch: expected x=%0d y=%0d color=%h we=%b last=%b",
                             checked, want.pixel_x, want.pixel_y, want.pixel_color,
                             want.write_enable, want.last);
                    $display("                    got      x=%0d y=%0d color=%h we=%b last=%b",
                             got.pixel_x, got.pixel_y, got.pixel_color,
                             got.write_enable, got.last);
                end
                mismatches++;
            end
        endfunction
    endclass

    logic                             i_clk = 1'b0;
    logic                             i_rst_n;
    logic                             i_cfg_we;
    logic [dda_pkg::CFG_IDX_W-1:0]    i_cfg_index;
    logic [dda_pkg::CFG_DATA_W-1:0]   i_cfg_wdata;

    dda_line_if line_if ();
    dda_pix_if  pix_if ();

    raster_scoreboard sb = new();

    int unsigned words_sent   = 0;
    int unsigned frame_sets   = 0;
    int unsigned tx_idle_pct  = 26;
    int unsigned rx_idle_pct  = 26;

    clipped_dda_line_rasterizer i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_line      (line_if),
        .o_pix       (pix_if)
    );

    always #5 i_clk = ~i_clk;

    function automatic int clamp(int v, int lo, int hi);
        return (v < lo) ? lo : (v > hi) ? hi : v;
    endfunction

    function automatic dda_pkg::t_line_word line_word(int sx, int sy, int ex, int ey,
                                                      int unsigned color, int wx, int wy);
        dda_pkg::t_line_word w;
        w.kind       = dda_pkg::KIND_LINE;
        w.start_x    = 16'(sx);
        w.start_y    = 16'(sy);
        w.end_x      = 16'(ex);
        w.end_y      = 16'(ey);
        w.line_color = 24'(color);
        w.window_x   = 12'(wx);
        w.window_y   = 12'(wy);
        return w;
    endfunction

    // Word with every field random; the kind is forced.
    function automatic dda_pkg::t_line_word random_word(dda_pkg::t_kind k);
        logic [127:0]        bits;
        dda_pkg::t_line_word w;
        bits   = {$urandom, $urandom, $urandom, $urandom};
        w      = bits[$bits(dda_pkg::t_line_word)-1:0];
        w.kind = k;
        return w;
    endfunction

    // Line of limited reach anywhere in the plane, window placed near its start.
    function automatic dda_pkg::t_line_word short_line(int reach);
        int sx, sy, ex, ey;
        sx = int'($urandom_range(65535)) - 32768;
        sy = int'($urandom_range(65535)) - 32768;
        ex = clamp(sx + int'($urandom_range(2 * reach)) - reach, -32768, 32767);
        ey = clamp(sy + int'($urandom_range(2 * reach)) - reach, -32768, 32767);
        return line_word(sx, sy, ex, ey, $urandom,
                         clamp((sx >>> 4) - int'($urandom_range(12)), -2048, 2047),
                         clamp((sy >>> 4) - int'($urandom_range(12)), -2048, 2047));
    endfunction

    // Number of pixels a line word draws, zero for a point.
    function automatic int pixel_count(dda_pkg::t_line_word w);
        int ax, ay, span;
        ax   = int'(w.end_x) - int'(w.start_x);
        ay   = int'(w.end_y) - int'(w.start_y);
        ax   = ax < 0 ? -ax : ax;
        ay   = ay < 0 ? -ay : ay;
        span = ax > ay ? ax : ay;
        return (span + dda_pkg::ROUND_UP) >>> dda_pkg::COORD_FRAC_BITS;
    endfunction

    // Offers one word after a random idle gap and returns on the edge it is taken.
    task automatic send_word(input dda_pkg::t_line_word w);
        while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
            line_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        line_if.valid <= 1'b1;
        line_if.word  <= w;
        @(posedge i_clk);
        while (line_if.ready !== 1'b1) @(posedge i_clk);
        sb.note_word(w);
        words_sent++;
    endtask

    task automatic send_steps(input int n);
        repeat (n) send_word(random_word(dda_pkg::KIND_STEP));
    endtask

    // Stops offering and waits until every predicted pixel has come out.
    task automatic wait_for_drain();
        line_if.valid <= 1'b0;
        while (sb.expected_pixels.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Drives one register write; the caller drops the write enable afterwards.
    task automatic write_register(input logic [dda_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [dda_pkg::FRAME_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        sb.set_register(idx, val);
    endtask

    task automatic apply_frame(input int unsigned width, input int unsigned height);
        write_register(dda_pkg::REG_FRAME_WIDTH, dda_pkg::FRAME_W'(width));
        write_register(dda_pkg::REG_FRAME_HEIGHT, dda_pkg::FRAME_W'(height));
        i_cfg_we <= 1'b0;
        frame_sets++;
    endtask

    // Hand-picked cases under the reset window size.
    task automatic run_directed();
        // Step before any line exists.
        send_steps(1);
        // Line of zero length, then a step with nothing to draw.
        send_word(line_word(320, 320, 320, 320, 24'h123456, 10, 10));
        send_steps(1);
        // Under one pixel long: the first pixel is also the last.
        send_word(line_word(100, 50, 105, 58, 24'hA5A5A5, 5, 2));
        send_steps(1);
        // Endpoints given right to left, abandoned after two steps.
        send_word(line_word(160, 48, 32, 112, 24'h5A5A5A, 1, 1));
        send_steps(2);
        // Corner-to-corner lines at the coordinate extremes.
        send_word(line_word(-32768, 32767, 32767, -32768, 24'hFFFFFF, -2048, -2048));
        send_steps(3);
        send_word(line_word(32767, -32768, -32768, 32767, 24'h000000, 2047, 2047));
        send_steps(1);
        // Steep line in negative space, run to its end and one step past.
        send_word(line_word(-48, -32, -16, -96, 24'h00FF00, -5, -8));
        send_steps(4);
        // Horizontal line with a fractional end, sitting on the window edge.
        send_word(line_word(8, 8, 63, 8, 24'h0000FF, 0, 0));
        send_steps(3);
    endtask

    // Mostly whole lines with random content, mixed with broken and noisy ones.
    task automatic run_random(input int unsigned count);
        int unsigned         stop;
        int unsigned         r;
        int                  steps;
        dda_pkg::t_line_word w;
        stop = words_sent + count;
        while (words_sent < stop) begin
            r = $urandom_range(99);
            if (r < 70) begin
                w = short_line(($urandom_range(9) == 0) ? 1600 : 320);
                send_word(w);
                steps = pixel_count(w) - 1;
                if (steps < 0) steps = 0;
                r = $urandom_range(99);
                if (r < 15 && steps > 0) begin
                    steps = $urandom_range(steps - 1);
                end else if (r < 25) begin
                    steps += $urandom_range(1, 3);
                end
                send_steps(steps);
            end else if (r < 82) begin
                send_word(random_word(dda_pkg::KIND_LINE));
                send_steps($urandom_range(4));
            end else if (r < 90) begin
                send_steps(1);
            end else begin
                // Points and sub-pixel lines.
                w = short_line(15);
                if ($urandom_range(1) == 1) begin
                    w.end_x = w.start_x;
                    w.end_y = w.start_y;
                end
                send_word(w);
                send_steps($urandom_range(1));
            end
        end
    endtask

    // Pixel sink: checks each taken word and stalls at random, with one long hold-off.
    initial begin : pixel_sink
        int unsigned hold_left;
        hold_left    = 0;
        pix_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n === 1'b1) begin
                if (pix_if.valid === 1'b1 && pix_if.ready === 1'b1) begin
                    sb.check_pixel(pix_if.word);
                    if (sb.checked == HOLD_AT) hold_left = HOLD_CYCLES;
                end
                if (hold_left != 0) begin
                    hold_left--;
                    pix_if.ready <= 1'b0;
                end else begin
                    pix_if.ready <= ($urandom_range(99) >= rx_idle_pct);
                end
            end
        end
    end

    // Watchdog: ends the run when no word has moved for too long.
    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if (i_rst_n !== 1'b1 ||
                (line_if.valid === 1'b1 && line_if.ready === 1'b1) ||
                (pix_if.valid === 1'b1 && pix_if.ready === 1'b1)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("timeout: no word moved for %0d cycles", QUIET_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

    // Main sequence: reset, directed cases, then random phases over window sizes.
    initial begin
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = '0;
        i_cfg_wdata   = '0;
        line_if.valid = 1'b0;
        line_if.word  = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        run_directed();
        wait_for_drain();

        apply_frame($urandom_range(1, 60), $urandom_range(1, 60));
        run_random(140);
        wait_for_drain();

        // No random idling on either side here.
        tx_idle_pct = 0;
        rx_idle_pct <= 0;
        apply_frame(2047, 2047);
        run_random(140);
        wait_for_drain();
        tx_idle_pct = 26;
        rx_idle_pct <= 26;

        apply_frame(0, 2047);
        run_random(140);
        wait_for_drain();

        apply_frame(2047, 0);
        run_random(140);
        wait_for_drain();

        apply_frame($urandom_range(2047), $urandom_range(2047));
        run_random(140);
        wait_for_drain();

        $display("Sent %0d words (%0d lines drawn) under %0d window sizes after reset.",
                 words_sent, sb.lines_started, frame_sets);
        $display("Checked %0d pixel words: %0d written, %0d empty, %0d mismatched.",
                 sb.checked, sb.written, sb.empties, sb.mismatches);
        if (sb.mismatches == 0 && sb.expected_pixels.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

`default_nettype wire

>>> sim.f
design/dda_pkg.sv
design/dda_line_if.sv
design/dda_pix_if.sv
design/dda_div.sv
design/dda_ctrl.sv
design/dda_dp.sv
design/clipped_dda_line_rasterizer.sv
dv/clipped_dda_line_rasterizer_test.sv
